@@ rtl/dwrr_class_scheduler_macros.svh @@
// Assertion macros for the DWRR class scheduler.
// Used by the top level; expects signals clk and rst in scope.
`ifndef DWRR_CLASS_SCHEDULER_MACROS_SVH
`define DWRR_CLASS_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define DWRR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define DWRR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dwrr_pkg.sv @@
// Shared types, widths and codes of the DWRR class scheduler.
// No dependencies; used by the interfaces and all modules.
package dwrr_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int MASK_W      = NUM_CLASSES;
  localparam int SIZE_W      = 16;
  localparam int WEIGHT_W    = 20;
  localparam int CAP_W       = 8;
  localparam int TOK_W       = WEIGHT_W + CAP_W;
  localparam int STATUS_W    = 2;
  localparam int CFG_ADDR_W  = $clog2(NUM_CLASSES + 1);
  localparam int CFG_DATA_W  = WEIGHT_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(1500);
  localparam logic [CAP_W-1:0]    CAP_RST    = CAP_W'(4);
  localparam logic [CLS_W-1:0]    LAST_RST   = CLS_W'(NUM_CLASSES - 1);

  // register index of the cap factor, after the weights
  localparam logic [CFG_ADDR_W-1:0] REG_CAP = CFG_ADDR_W'(NUM_CLASSES);

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd2;

  typedef logic [SIZE_W-1:0] size_t;

  // controller -> datapath
  typedef struct packed {
    logic idle;     // ready for a request transaction
    logic commit;   // write result, charge tokens
    logic refresh;  // add weights, capped
    logic second;   // search after refresh
  } dwrr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_valid;
    logic fit;
    logic seen;
    logic out_free;
  } dwrr_sts_t;

endpackage

@@ rtl/dwrr_if.sv @@
// Channel interfaces of the DWRR class scheduler: request, result, config.
// Depends on dwrr_pkg.
interface dwrr_req_if import dwrr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] occupied_mask;
  size_t             head_size_0;
  size_t             head_size_1;
  size_t             head_size_2;
  size_t             head_size_3;
  modport source (output valid, occupied_mask, head_size_0, head_size_1,
                  head_size_2, head_size_3, input ready);
  modport sink   (input valid, occupied_mask, head_size_0, head_size_1,
                  head_size_2, head_size_3, output ready);
endinterface

interface dwrr_res_if import dwrr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CLS_W-1:0]    chosen_class;
  logic [STATUS_W-1:0] status;
  logic                refilled;
  modport source (output valid, chosen_class, status, refilled, input ready);
  modport sink   (input valid, chosen_class, status, refilled, output ready);
endinterface

interface dwrr_cfg_if import dwrr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

@@ rtl/dwrr_ctrl.sv @@
// Sequencer of the DWRR class scheduler: search, refresh, second search.
// Depends on dwrr_pkg.
module dwrr_ctrl import dwrr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dwrr_sts_t sts,
  output dwrr_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH1 = 2'd1;
  localparam logic [1:0] S_REFR  = 2'd2;
  localparam logic [1:0] S_SRCH2 = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.req_valid) begin
          state_next = S_SRCH1;
        end
      end
      S_SRCH1: begin
        if (sts.seen && !sts.fit) begin
          state_next = S_REFR;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REFR: begin
        cmd.refresh = 1'b1;
        state_next  = S_SRCH2;
      end
      S_SRCH2: begin
        cmd.second = 1'b1;
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/dwrr_dp.sv @@
// Datapath of the DWRR class scheduler: weights, tokens, search, result register.
// Depends on dwrr_pkg and the channel interfaces.
module dwrr_dp import dwrr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dwrr_req_if.sink   req,
  dwrr_res_if.source res,
  dwrr_cfg_if.sink   cfg,
  input  dwrr_cmd_t  cmd,
  output dwrr_sts_t  sts
);

  logic [WEIGHT_W-1:0] weight  [NUM_CLASSES];
  logic [TOK_W-1:0]    tokens  [NUM_CLASSES];
  logic [TOK_W-1:0]    ceil_r  [NUM_CLASSES];
  logic [TOK_W-1:0]    tok_ref [NUM_CLASSES];
  size_t               size_r  [NUM_CLASSES];
  logic [CAP_W-1:0]    cap;
  logic [CLS_W-1:0]    last;
  logic [MASK_W-1:0]   mask_r;
  logic [NUM_CLASSES-1:0] fits;
  logic                found;
  logic [CLS_W-1:0]    pick;
  logic                out_valid;
  logic [CLS_W-1:0]    out_class;
  logic [STATUS_W-1:0] out_status;
  logic                out_refilled;
  logic [STATUS_W-1:0] status_new;

  assign req.ready = cmd.idle;
  assign cfg.ready = 1'b1;

  assign res.valid        = out_valid;
  assign res.chosen_class = out_class;
  assign res.status       = out_status;
  assign res.refilled     = out_refilled;

  assign sts.req_valid = req.valid;
  assign sts.fit       = found;
  assign sts.seen      = |mask_r;
  assign sts.out_free  = !out_valid || res.ready;

  // per-class fit and capped refresh value
  always_comb begin
    logic [TOK_W:0] sum;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      fits[i]    = mask_r[i] && (tokens[i] >= TOK_W'(size_r[i]));
      sum        = {1'b0, tokens[i]} + (TOK_W+1)'(weight[i]);
      tok_ref[i] = (sum < {1'b0, ceil_r[i]}) ? sum[TOK_W-1:0] : ceil_r[i];
    end
  end

  // round-robin pick, starting after the last class chosen
  always_comb begin
    logic [CLS_W:0] idx;
    found = 1'b0;
    pick  = '0;
    for (int k = 1; k <= NUM_CLASSES; k++) begin
      idx = (CLS_W+1)'(last) + (CLS_W+1)'(k);
      if (idx >= (CLS_W+1)'(NUM_CLASSES)) begin
        idx = idx - (CLS_W+1)'(NUM_CLASSES);
      end
      if (!found && fits[idx[CLS_W-1:0]]) begin
        found = 1'b1;
        pick  = idx[CLS_W-1:0];
      end
    end
  end

  always_comb begin
    if (cmd.second) begin
      status_new = found ? ST_OK : ST_NOFIT;
    end else begin
      status_new = sts.seen ? ST_OK : ST_EMPTY;
    end
  end

  // scheduler state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        weight[i] <= WEIGHT_RST;
        tokens[i] <= TOK_W'(WEIGHT_RST);
      end
      cap       <= CAP_RST;
      last      <= LAST_RST;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.addr < REG_CAP) begin
          weight[cfg.addr[CLS_W-1:0]] <= cfg.wdata[WEIGHT_W-1:0];
          tokens[cfg.addr[CLS_W-1:0]] <= TOK_W'(cfg.wdata[WEIGHT_W-1:0]);
        end else if (cfg.addr == REG_CAP) begin
          cap <= cfg.wdata[CAP_W-1:0];
        end
      end else if (cmd.refresh) begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
          tokens[i] <= tok_ref[i];
        end
      end else if (cmd.commit && found) begin
        tokens[pick] <= tokens[pick] - TOK_W'(size_r[pick]);
        last         <= pick;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      ceil_r[i] <= TOK_W'(weight[i]) * TOK_W'(cap);
    end
    if (req.valid && cmd.idle) begin
      mask_r    <= req.occupied_mask;
      size_r[0] <= req.head_size_0;
      size_r[1] <= req.head_size_1;
      size_r[2] <= req.head_size_2;
      size_r[3] <= req.head_size_3;
    end
    if (cmd.commit) begin
      out_class    <= found ? pick : '0;
      out_status   <= status_new;
      out_refilled <= cmd.second;
    end
  end

endmodule

@@ rtl/dwrr_class_scheduler.sv @@
// Top level of the deficit weighted round robin class scheduler.
// Depends on dwrr_pkg, the channel interfaces, dwrr_ctrl, dwrr_dp and the macro header.
//
//  Channel | Role | Payload
//  --------+------+------------------------------------------------
//  req     | in   | occupied_mask, head_size_0 .. head_size_3
//  res     | out  | chosen_class, status, refilled
//  cfg     | in   | addr (0-3 weight_i, 4 token cap multiple), wdata
//
// Sequence: each request transaction is accepted, then one search runs
//   over all classes; a refresh round adds a refresh and a second search
//   after the first search. The single-pass sequencer in dwrr_ctrl sets this order.
// Reset: weights and tokens 1500, cap factor 4, last chosen class 3.
//   No clearing pass.
// Stalls: the result sits in an output register; the next request is
//   taken while it waits. A search only completes when that register is
//   free or being taken, otherwise the sequencer holds.
`include "dwrr_class_scheduler_macros.svh"

module dwrr_class_scheduler import dwrr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dwrr_req_if.sink   req,
  dwrr_res_if.source res,
  dwrr_cfg_if.sink   cfg
);

  dwrr_cmd_t cmd;
  dwrr_sts_t sts;

  // sequencer: idle -> search -> (refresh -> search) -> idle
  dwrr_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // token store, round-robin search, result register and config registers
  dwrr_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

  // a completed search always shows up on the result channel
  `DWRR_ASSERT_NXT(a_commit_shows, cmd.commit, res.valid, "commit lost")
  // refresh is a single step, never repeated back to back
  `DWRR_ASSERT_NXT(a_refresh_once, cmd.refresh, !cmd.refresh, "refresh repeated")
  // nothing-fits is only ever reported after a refresh round
  `DWRR_ASSERT_IMP(a_nofit_refilled, res.valid && res.status == ST_NOFIT, res.refilled,
    "nofit without refresh")
  // all-empty never refreshes and reports class zero
  `DWRR_ASSERT_IMP(a_empty_plain, res.valid && res.status == ST_EMPTY,
    !res.refilled && res.chosen_class == '0, "empty result malformed")

endmodule
